// ===== sv/idf_pkg.sv =====
package idf_pkg;

	// field and register widths
	localparam int PIX_W    = 4;
	localparam int WIDTH_W  = 6;
	localparam int HEIGHT_W = 10;
	localparam int THRESH_W = 4;
	localparam int CFG_W    = 10;

	// neighbour sum: four pixels of 15 at most
	localparam int SUM_W = 6;
	// column arithmetic, holds a column plus two and the widest row
	localparam int POS_W = 7;

	// register defaults and limits
	localparam int WIDTH_MIN    = 2;
	localparam int HEIGHT_MIN   = 2;
	localparam int WIDTH_RESET  = 30;
	localparam int HEIGHT_RESET = 20;
	localparam int THRESH_RESET = 1;

	// x / 3 as (x * 43) >> 7, exact for x below 128
	localparam int RECIP3    = 43;
	localparam int RECIP3_SH = 7;
	localparam int PROD_W    = 12;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} cfg_reg_t;

	// which neighbours exist for the pixel being judged
	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
	} nb_sel_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             replaced;
		logic             last;
	} result_t;

endpackage

// ===== sv/idf_ram.sv =====
module idf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/idf_judge.sv =====
module idf_judge (
	input  logic [idf_pkg::THRESH_W-1:0] thresh,
	input  logic [idf_pkg::PIX_W-1:0]    center,
	input  logic [idf_pkg::PIX_W-1:0]    up,
	input  logic [idf_pkg::PIX_W-1:0]    down,
	input  logic [idf_pkg::PIX_W-1:0]    left,
	input  logic [idf_pkg::PIX_W-1:0]    right,
	input  idf_pkg::nb_sel_t             sel,
	input  logic                         last,
	output idf_pkg::result_t             res
);

	logic [idf_pkg::PIX_W:0]    ctr_x;
	logic                       ok_up, ok_down, ok_left, ok_right;
	logic                       spike;
	logic [idf_pkg::SUM_W-1:0]  sum, sum_r1, sum_r2;
	logic [2:0]                 n;
	logic [idf_pkg::PROD_W-1:0] prod3;
	logic [idf_pkg::PIX_W-1:0]  avg;

	// a neighbour passes the test when center > neighbour + threshold
	assign ctr_x    = {1'b0, center};
	assign ok_up    = !sel.up    || (ctr_x > ({1'b0, up} + {1'b0, thresh}));
	assign ok_down  = !sel.down  || (ctr_x > ({1'b0, down} + {1'b0, thresh}));
	assign ok_left  = !sel.left  || (ctr_x > ({1'b0, left} + {1'b0, thresh}));
	assign ok_right = !sel.right || (ctr_x > ({1'b0, right} + {1'b0, thresh}));
	assign spike    = ok_up && ok_down && ok_left && ok_right;

	// sum and count of the neighbours present
	assign sum = idf_pkg::SUM_W'(sel.up    ? up    : '0)
	           + idf_pkg::SUM_W'(sel.down  ? down  : '0)
	           + idf_pkg::SUM_W'(sel.left  ? left  : '0)
	           + idf_pkg::SUM_W'(sel.right ? right : '0);
	assign n = 3'(sel.up) + 3'(sel.down) + 3'(sel.left) + 3'(sel.right);

	assign sum_r1 = sum + idf_pkg::SUM_W'(1);
	assign sum_r2 = sum + idf_pkg::SUM_W'(2);
	assign prod3  = idf_pkg::PROD_W'(sum_r1) * idf_pkg::PROD_W'(idf_pkg::RECIP3);

	// average rounded half up
	always_comb begin
		unique case (n)
			3'd2:    avg = sum_r1[idf_pkg::PIX_W:1];
			3'd3:    avg = prod3[idf_pkg::RECIP3_SH +: idf_pkg::PIX_W];
			3'd4:    avg = sum_r2[idf_pkg::PIX_W+1:2];
			default: avg = center;
		endcase
	end

	always_comb begin
		res.pixel    = spike ? avg : center;
		res.replaced = spike;
		res.last     = last;
	end

endmodule

// ===== sv/image_despeckle_filter_top.sv =====
// Four-neighbour impulse noise filter on a raster stream of 4-bit gray pixels.
// Input channel: in_valid / in_stall / pixel_in, one pixel per beat in raster
// order. Output channel: out_valid / out_stall / pixel_out, was_replaced,
// frame_last, one filtered pixel per beat, also in raster order.
// Config port: cfg_write / cfg_index / cfg_data; 0 width, 1 height,
// 2 threshold. A write to any of these restarts the frame at row 0, column 0.
// Throughput: one pixel per cycle while in_stall is low. Each pixel is judged
// when its down neighbour arrives, so a result comes out one row after its
// input and enters the output queue when the down neighbour's beat is taken.
// The final input of a frame starts a flush of the last row: image_width
// beats, one per cycle while the queue has room, during which in_stall is
// high. The first row of a frame gives no results. The column store is a
// single memory read one column ahead of the window.
// Stall: a two-entry output queue sits between the sides; in_stall comes from
// registers only and rises when the queue is full or a flush runs.
// Reset: width 30, height 20, threshold 1, frame position zero, queue empty.
// The column store is not cleared; no output depends on an unwritten entry.
module image_despeckle_filter_top #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [idf_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [idf_pkg::PIX_W-1:0]   pixel_in,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [idf_pkg::PIX_W-1:0]   pixel_out,
	output logic                        was_replaced,
	output logic                        frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = idf_pkg::PIX_W;
	localparam int W_RESET_EFF =
		(idf_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : idf_pkg::WIDTH_RESET;

	// configuration, kept as effective (clamped) values
	logic [idf_pkg::WIDTH_W-1:0]  w_q, w_new;
	logic [idf_pkg::HEIGHT_W-1:0] h_q, h_new;
	logic [idf_pkg::THRESH_W-1:0] th_q;
	logic                         cfg_hit;

	// frame position and flush sequencer
	logic [CW-1:0]                col_q, fcol_q, step_col;
	logic [idf_pkg::HEIGHT_W-1:0] row_q;
	logic                         flush_q;

	// window: cur_q = {row above, two rows above} at the current column
	logic [2*PW-1:0] cur_q, ahead, rd_data, wr_data, byp_data_q;
	logic [PW-1:0]   left_q;
	logic            byp_q;

	logic                  in_fire, flush_step, step, push, pop;
	logic                  col_end, frame_end, fcol_end;
	logic [idf_pkg::POS_W-1:0] nxt_pos, rd_pos, w_pos;
	logic [CW-1:0]         rd_addr;
	idf_pkg::nb_sel_t      sel;
	idf_pkg::result_t      res, q0_q, q1_q;
	logic [1:0]            cnt_q, cnt_kept;

	// config decode with clamping
	always_comb begin
		w_new = cfg_data[idf_pkg::WIDTH_W-1:0];
		if (w_new < idf_pkg::WIDTH_W'(idf_pkg::WIDTH_MIN)) begin
			w_new = idf_pkg::WIDTH_W'(idf_pkg::WIDTH_MIN);
		end else if (w_new > idf_pkg::WIDTH_W'(MAX_WIDTH)) begin
			w_new = idf_pkg::WIDTH_W'(MAX_WIDTH);
		end
		h_new = cfg_data[idf_pkg::HEIGHT_W-1:0];
		if (h_new < idf_pkg::HEIGHT_W'(idf_pkg::HEIGHT_MIN)) begin
			h_new = idf_pkg::HEIGHT_W'(idf_pkg::HEIGHT_MIN);
		end
	end

	always_comb begin
		unique case (idf_pkg::cfg_reg_t'(cfg_index))
			idf_pkg::REG_WIDTH,
			idf_pkg::REG_HEIGHT,
			idf_pkg::REG_THRESH: cfg_hit = cfg_write;
			default:             cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= idf_pkg::WIDTH_W'(W_RESET_EFF);
			h_q  <= idf_pkg::HEIGHT_W'(idf_pkg::HEIGHT_RESET);
			th_q <= idf_pkg::THRESH_W'(idf_pkg::THRESH_RESET);
		end else if (cfg_write) begin
			unique case (idf_pkg::cfg_reg_t'(cfg_index))
				idf_pkg::REG_WIDTH:  w_q  <= w_new;
				idf_pkg::REG_HEIGHT: h_q  <= h_new;
				idf_pkg::REG_THRESH: th_q <= cfg_data[idf_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake and step control
	assign in_stall   = (cnt_q == 2'd2) || flush_q;
	assign in_fire    = in_valid && !in_stall;
	assign flush_step = flush_q && (cnt_q != 2'd2);
	assign step       = in_fire || flush_step;
	assign step_col   = flush_q ? fcol_q : col_q;

	assign w_pos     = idf_pkg::POS_W'(w_q);
	assign col_end   = (idf_pkg::POS_W'(col_q) + idf_pkg::POS_W'(1)) == w_pos;
	assign fcol_end  = (idf_pkg::POS_W'(fcol_q) + idf_pkg::POS_W'(1)) == w_pos;
	assign frame_end = col_end && ((row_q + idf_pkg::HEIGHT_W'(1)) == h_q);

	// prefetch two columns ahead, wrapping into the next row
	assign nxt_pos = idf_pkg::POS_W'(step_col) + idf_pkg::POS_W'(2);
	assign rd_pos  = (nxt_pos >= w_pos) ? (nxt_pos - w_pos) : nxt_pos;
	assign rd_addr = rd_pos[CW-1:0];

	assign wr_data = {pixel_in, cur_q[2*PW-1:PW]};
	assign ahead   = byp_q ? byp_data_q : rd_data;

	idf_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_WIDTH)
	) u_col_store (
		.clk   (clk),
		.we    (in_fire),
		.waddr (col_q),
		.wdata (wr_data),
		.re    (step),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// same-address read and write (two-pixel rows): forward the new entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (step) begin
			byp_q <= in_fire && (rd_addr == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			byp_data_q <= wr_data;
		end
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			left_q <= '0;
		end else if (step) begin
			left_q <= cur_q[2*PW-1:PW];
			cur_q  <= ahead;
		end
	end

	// frame position and flush
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= 1'b0;
			fcol_q  <= '0;
		end else if (cfg_hit) begin
			col_q   <= '0;
			row_q   <= '0;
			flush_q <= 1'b0;
			fcol_q  <= '0;
		end else if (in_fire) begin
			priority if (frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				flush_q <= 1'b1;
				fcol_q  <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + idf_pkg::HEIGHT_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end else if (flush_step) begin
			if (fcol_end) begin
				flush_q <= 1'b0;
			end else begin
				fcol_q <= fcol_q + CW'(1);
			end
		end
	end

	// neighbours of the pixel being judged
	always_comb begin
		sel.up    = flush_q || (row_q >= idf_pkg::HEIGHT_W'(2));
		sel.down  = !flush_q;
		sel.left  = step_col != '0;
		sel.right = (idf_pkg::POS_W'(step_col) + idf_pkg::POS_W'(1)) < w_pos;
	end

	idf_judge u_judge (
		.thresh (th_q),
		.center (cur_q[2*PW-1:PW]),
		.up     (cur_q[PW-1:0]),
		.down   (pixel_in),
		.left   (left_q),
		.right  (ahead[2*PW-1:PW]),
		.sel    (sel),
		.last   (flush_q && fcol_end),
		.res    (res)
	);

	// two-entry output queue
	assign push     = flush_step || (in_fire && (row_q != '0));
	assign pop      = out_valid && !out_stall;
	assign cnt_kept = cnt_q - 2'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_kept + 2'(push);
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (cnt_q == 2'd2)) begin
			q0_q <= q1_q;
		end
		if (push) begin
			if (cnt_kept == 2'd0) begin
				q0_q <= res;
			end else begin
				q1_q <= res;
			end
		end
	end

	assign out_valid    = cnt_q != 2'd0;
	assign pixel_out    = q0_q.pixel;
	assign was_replaced = q0_q.replaced;
	assign frame_last   = q0_q.last;

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		idf_pkg::POS_W'(col_q) < w_pos)
		else $error("column position beyond row width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < h_q)
		else $error("row position beyond frame height");

	a_flush_pos: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (col_q == '0) && (row_q == '0))
		else $error("frame position not restarted during flush");

	a_queue_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue overflow");

	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(flush_step && res.last) |=> !flush_q)
		else $error("flush continued past the last column");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int MAX_COLS = 32;
	localparam int STORE_DEPTH = 2 * MAX_COLS;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_TARGET = 290;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_LIMIT = 10;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_write;
	logic [1:0]                 cfg_index;
	logic [idf_pkg::CFG_W-1:0]  cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [idf_pkg::PIX_W-1:0]  pixel_in;
	logic                       out_valid;
	logic                       out_stall;
	logic [idf_pkg::PIX_W-1:0]  pixel_out;
	logic                       was_replaced;
	logic                       frame_last;

	// filter mirror: registers, frame position and the last two rows
	logic [idf_pkg::WIDTH_W-1:0]  width_reg;
	logic [idf_pkg::HEIGHT_W-1:0] height_reg;
	logic [idf_pkg::THRESH_W-1:0] thresh_reg;
	logic [idf_pkg::PIX_W-1:0]    line_buf [STORE_DEPTH];
	int unsigned                  col_pos;
	int unsigned                  row_pos;
	idf_pkg::result_t             pending_pixels [$];

	int unsigned error_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned cycle_count = 0;
	bit          bursts_on;
	bit          hold_go;

	image_despeckle_filter_top #(.MAX_WIDTH(MAX_COLS)) uut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
				pending_pixels.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned used_width();
		int unsigned w;
		w = 32'(width_reg);
		if (w < idf_pkg::WIDTH_MIN) w = idf_pkg::WIDTH_MIN;
		if (w > MAX_COLS) w = MAX_COLS;
		return w;
	endfunction

	function automatic int unsigned used_height();
		int unsigned h;
		h = 32'(height_reg);
		if (h < idf_pkg::HEIGHT_MIN) h = idf_pkg::HEIGHT_MIN;
		return h;
	endfunction

	// spike test against n neighbors packed four bits each in taps
	function automatic idf_pkg::result_t judge_pixel(
		input logic [idf_pkg::PIX_W-1:0] center,
		input logic [15:0] taps, input int unsigned n, input logic last);
		int unsigned sum;
		int unsigned tap;
		int unsigned avg;
		bit spike;
		idf_pkg::result_t res;
		sum = 0;
		spike = 1'b1;
		for (int unsigned i = 0; i < n; i++) begin
			tap = 32'(taps[4*i +: 4]);
			sum += tap;
			if (!(32'(center) > tap && 32'(center) - tap > 32'(thresh_reg)))
				spike = 1'b0;
		end
		// average rounded half up
		avg = (sum + n / 2) / n;
		res.pixel = spike ? avg[idf_pkg::PIX_W-1:0] : center;
		res.replaced = spike;
		res.last = last;
		return res;
	endfunction

	// one accepted pixel: judge the pixel above it, shift the row store, flush at frame end
	function automatic void despeckle_pixel(input logic [idf_pkg::PIX_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int unsigned n;
		int unsigned d;
		logic [15:0] taps;
		w = used_width();
		h = used_height();
		c = col_pos;
		r = row_pos;
		if (c >= w) c = w - 1;
		if (r >= h) r = h - 1;
		if (r >= 1) begin
			taps = {12'd0, px};
			n = 1;
			if (r >= 2) begin
				taps = {taps[11:0], line_buf[2*w-1]};
				n++;
			end
			if (c > 0) begin
				taps = {taps[11:0], line_buf[w]};
				n++;
			end
			if (c + 1 < w) begin
				taps = {taps[11:0], line_buf[w-2]};
				n++;
			end
			pending_pixels.push_back(judge_pixel(line_buf[w-1], taps, n, 1'b0));
		end
		for (int i = STORE_DEPTH - 1; i > 0; i--) line_buf[i] = line_buf[i-1];
		line_buf[0] = px;
		if (r + 1 == h && c + 1 == w) begin
			// last row has no down neighbor, judged all at once
			for (int unsigned col = 0; col < w; col++) begin
				d = w - 1 - col;
				taps = {12'd0, line_buf[d+w]};
				n = 1;
				if (col > 0) begin
					taps = {taps[11:0], line_buf[d+1]};
					n++;
				end
				if (col + 1 < w) begin
					taps = {taps[11:0], line_buf[d-1]};
					n++;
				end
				pending_pixels.push_back(judge_pixel(line_buf[d], taps, n, col + 1 == w));
			end
			col_pos = 0;
			row_pos = 0;
		end else if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	// output beat check against the oldest expectation
	always @(posedge clk) begin : check_beat
		idf_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				if (error_count < REPORT_LIMIT)
					$display("cycle %0d: unexpected beat pixel %0d replaced %0b last %0b",
						cycle_count, pixel_out, was_replaced, frame_last);
				error_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_out !== want.pixel || was_replaced !== want.replaced ||
						frame_last !== want.last) begin
					if (error_count < REPORT_LIMIT)
						$display({"cycle %0d: expected pixel %0d replaced %0b last %0b,",
							" got pixel %0d replaced %0b last %0b"}, cycle_count,
							want.pixel, want.replaced, want.last,
							pixel_out, was_replaced, frame_last);
					error_count++;
				end
			end
		end
	end

	// receiver: random stall bursts, or one long hold when a test asks for it
	initial begin : drive_out_stall
		int unsigned run;
		bit stall_now;
		out_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_go) begin
				hold_go = 1'b0;
				stall_now = 1'b1;
				run = HOLD_CYCLES;
			end else if (bursts_on) begin
				stall_now = $urandom_range(0, 2) == 0;
				run = $urandom_range(1, 12);
			end else begin
				stall_now = 1'b0;
				run = 1;
			end
			out_stall <= stall_now;
			repeat (run) @(posedge clk);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [idf_pkg::CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			idf_pkg::REG_WIDTH:  width_reg = data[idf_pkg::WIDTH_W-1:0];
			idf_pkg::REG_HEIGHT: height_reg = data;
			idf_pkg::REG_THRESH: thresh_reg = data[idf_pkg::THRESH_W-1:0];
			default: ;
		endcase
		// a real register write restarts the frame
		if (idx != REG_UNUSED) begin
			col_pos = 0;
			row_pos = 0;
		end
		@(posedge clk);
	endtask

	// offer one beat, hold it until taken
	task automatic send_pixel(input logic [idf_pkg::PIX_W-1:0] px);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= px;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		despeckle_pixel(px);
		pixels_sent++;
	endtask

	// smooth background near a base level with occasional bright speckles, or uniform noise
	function automatic logic [idf_pkg::PIX_W-1:0] speckle_pixel(input int unsigned base,
		input bit noise);
		int unsigned v;
		if (noise) v = $urandom_range(0, 15);
		else if ($urandom_range(0, 5) == 0) v = $urandom_range(base + 3, 15);
		else v = base + $urandom_range(0, 2);
		return v[idf_pkg::PIX_W-1:0];
	endfunction

	task automatic send_pixels(input int unsigned count, input bit noise);
		int unsigned base;
		base = $urandom_range(0, 8);
		repeat (count) send_pixel(speckle_pixel(base, noise));
	endtask

	task automatic wait_drained(input int unsigned settle);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// default geometry after reset, row 0 plus part of row 1
	task automatic test_reset_defaults();
		send_pixels(40, 1'b0);
		wait_drained(SETTLE_CYCLES);
	endtask

	// clamped 2x2 frames: corner spikes with two neighbors, threshold zero
	task automatic test_corner_frames();
		logic [idf_pkg::PIX_W-1:0] px [8] =
			'{4'd15, 4'd0, 4'd1, 4'd0, 4'd0, 4'd14, 4'd15, 4'd13};
		write_reg(idf_pkg::REG_WIDTH, 10'h3C1);
		write_reg(idf_pkg::REG_HEIGHT, 10'h001);
		write_reg(idf_pkg::REG_THRESH, 10'h3F0);
		foreach (px[i]) send_pixel(px[i]);
		wait_drained(SETTLE_CYCLES);
	endtask

	// 3x3 center spike of full swing at the top threshold and just below it
	task automatic test_threshold_limits();
		logic [idf_pkg::PIX_W-1:0] px [9] =
			'{4'd0, 4'd0, 4'd0, 4'd0, 4'd15, 4'd0, 4'd0, 4'd0, 4'd0};
		write_reg(idf_pkg::REG_WIDTH, 10'h003);
		write_reg(idf_pkg::REG_HEIGHT, 10'h003);
		write_reg(idf_pkg::REG_THRESH, 10'h00F);
		foreach (px[i]) send_pixel(px[i]);
		wait_drained(SETTLE_CYCLES);
		write_reg(idf_pkg::REG_THRESH, 10'h3CE);
		px[7] = 4'd2;
		foreach (px[i]) send_pixel(px[i]);
		wait_drained(SETTLE_CYCLES);
	endtask

	// oversized width clamps to the widest row; the last input flushes a full row
	task automatic test_widest_row();
		write_reg(idf_pkg::REG_WIDTH, 10'h3FF);
		write_reg(idf_pkg::REG_HEIGHT, 10'h002);
		write_reg(idf_pkg::REG_THRESH, 10'h002);
		send_pixels(2 * MAX_COLS, 1'b0);
		wait_drained(SETTLE_CYCLES);
	endtask

	// tallest frame, abandoned early; a write to the unused index keeps the position
	task automatic test_tall_frame();
		write_reg(idf_pkg::REG_WIDTH, 10'h3C2);
		write_reg(idf_pkg::REG_HEIGHT, 10'h3FF);
		write_reg(idf_pkg::REG_THRESH, 10'h001);
		send_pixels(15, 1'b0);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_UNUSED, 10'($urandom));
		send_pixels(15, 1'b0);
		wait_drained(SETTLE_CYCLES);
	endtask

	// sender pause mid frame, then a long receiver hold so the input backs up
	task automatic test_output_hold();
		write_reg(idf_pkg::REG_WIDTH, 10'h005);
		write_reg(idf_pkg::REG_HEIGHT, 10'h006);
		write_reg(idf_pkg::REG_THRESH, 10'h000);
		send_pixels(10, 1'b0);
		wait_drained(SETTLE_CYCLES);
		hold_go = 1'b1;
		send_pixels(20, 1'b0);
		wait_drained(SETTLE_CYCLES);
	endtask

	// random geometry and content; some frames are noise, some are cut short
	task automatic test_random_frames();
		int unsigned sel;
		int unsigned wfield;
		int unsigned hfield;
		int unsigned tfield;
		int unsigned count;
		logic [idf_pkg::CFG_W-1:0] cfg_word;
		bit noise;
		while (pixels_sent < RANDOM_TARGET) begin
			sel = $urandom_range(0, 15);
			if (sel == 0) wfield = $urandom_range(0, 1);
			else if (sel == 1) wfield = $urandom_range(32, 63);
			else wfield = $urandom_range(2, 7);
			hfield = (sel == 1) ? 2 : $urandom_range(0, 4);
			tfield = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
			cfg_word = 10'($urandom);
			cfg_word[idf_pkg::WIDTH_W-1:0] = wfield[idf_pkg::WIDTH_W-1:0];
			write_reg(idf_pkg::REG_WIDTH, cfg_word);
			write_reg(idf_pkg::REG_HEIGHT, hfield[idf_pkg::HEIGHT_W-1:0]);
			cfg_word = 10'($urandom);
			cfg_word[idf_pkg::THRESH_W-1:0] = tfield[idf_pkg::THRESH_W-1:0];
			write_reg(idf_pkg::REG_THRESH, cfg_word);
			count = used_width() * used_height();
			if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count - 1);
			noise = $urandom_range(0, 3) == 0;
			send_pixels(count, noise);
			wait_drained(SETTLE_CYCLES);
		end
	endtask

	// closing frame at full rate on both sides
	task automatic test_steady_stream();
		bursts_on = 1'b0;
		write_reg(idf_pkg::REG_WIDTH, 10'h006);
		write_reg(idf_pkg::REG_HEIGHT, 10'h005);
		write_reg(idf_pkg::REG_THRESH, 10'($urandom_range(0, 3)));
		send_pixels(30, 1'b0);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= idf_pkg::REG_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		pixel_in <= '0;
		bursts_on = 1'b1;
		hold_go = 1'b0;
		width_reg = idf_pkg::WIDTH_W'(idf_pkg::WIDTH_RESET);
		height_reg = idf_pkg::HEIGHT_W'(idf_pkg::HEIGHT_RESET);
		thresh_reg = idf_pkg::THRESH_W'(idf_pkg::THRESH_RESET);
		col_pos = 0;
		row_pos = 0;
		foreach (line_buf[i]) line_buf[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_corner_frames();
		test_threshold_limits();
		test_widest_row();
		test_tall_frame();
		test_output_hold();
		test_random_frames();
		test_steady_stream();
		wait_drained(DRAIN_CYCLES);

		if (error_count == 0 && pending_pixels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			if (pending_pixels.size() != 0)
				$display("%0d expected beats never arrived", pending_pixels.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
